### hdl/vphp_pkg.sv
// ----------------------------------------------------------------------------
// vphp_pkg
// Shared codes and widths for the varint packet header parser.
// ----------------------------------------------------------------------------
package vphp_pkg;

    localparam int unsigned DATA_W   = 8;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 3;
    localparam int unsigned PHASE_W  = 2;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG   = 2'd2;

    localparam logic [PHASE_W-1:0] PH_LENGTH = 2'd0;
    localparam logic [PHASE_W-1:0] PH_ID     = 2'd1;
    localparam logic [PHASE_W-1:0] PH_SKIP   = 2'd2;

    localparam logic [DATA_W-1:0] PAYLOAD_MASK = 8'b0111_1111;
    localparam logic [DATA_W-1:0] MORE_MASK    = 8'b1000_0000;

endpackage

### hdl/varint_packet_header_parser_core.sv
// ----------------------------------------------------------------------------
// varint_packet_header_parser_core
// An accepted byte passes through an input register, then a result register.
// One byte is accepted every cycle while the input is not stalled; the decode step
// between the two registers sets that rate. Reset is asynchronous, active low.
// ----------------------------------------------------------------------------
module varint_packet_header_parser_core #(
    parameter int unsigned MAX_VARINT_BYTES = 5
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [vphp_pkg::DATA_W-1:0]          data_byte,
    input  logic                                 buffer_end,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [vphp_pkg::STATUS_W-1:0]        status,
    output logic signed [vphp_pkg::VALUE_W-1:0]  packet_length,
    output logic signed [vphp_pkg::VALUE_W-1:0]  packet_id,
    output logic [vphp_pkg::COUNT_W-1:0]         length_bytes
);

    localparam int unsigned IDX_W = $clog2(MAX_VARINT_BYTES + 1);
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_VARINT_BYTES);

    logic                             s1_valid_reg, s1_valid_next;
    logic [vphp_pkg::DATA_W-1:0]      s1_byte_reg;
    logic                             s1_end_reg;

    logic [vphp_pkg::PHASE_W-1:0]     phase_reg, phase_next;
    logic [vphp_pkg::VALUE_W-1:0]     acc_reg, acc_next;
    logic [IDX_W-1:0]                 idx_reg, idx_next;
    logic [vphp_pkg::VALUE_W-1:0]     held_len_reg, held_len_next;
    logic [IDX_W-1:0]                 held_bytes_reg, held_bytes_next;

    logic                             out_valid_reg, out_valid_next;
    logic [vphp_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic [vphp_pkg::VALUE_W-1:0]     len_out_reg, len_out_next;
    logic [vphp_pkg::VALUE_W-1:0]     id_out_reg, id_out_next;
    logic [IDX_W-1:0]                 lbytes_out_reg, lbytes_out_next;

    logic                             s1_adv;
    logic                             fire;
    logic                             emit;
    logic [5:0]                       shift_amt;
    logic [vphp_pkg::VALUE_W-1:0]     acc_new;
    logic [IDX_W-1:0]                 idx_new;

    assign s1_adv   = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !s1_adv;
    assign fire     = s1_valid_reg && s1_adv;

    assign shift_amt = 6'(7 * idx_reg);
    assign acc_new   = acc_reg
                     | ({{(vphp_pkg::VALUE_W - vphp_pkg::DATA_W){1'b0}},
                         s1_byte_reg & vphp_pkg::PAYLOAD_MASK} << shift_amt);
    assign idx_new   = idx_reg + 1'b1;

    always_comb
    begin
        phase_next      = phase_reg;
        acc_next        = acc_reg;
        idx_next        = idx_reg;
        held_len_next   = held_len_reg;
        held_bytes_next = held_bytes_reg;
        emit            = 1'b0;
        status_next     = status_reg;
        len_out_next    = len_out_reg;
        id_out_next     = id_out_reg;
        lbytes_out_next = lbytes_out_reg;

        if (fire)
        begin
            if (phase_reg != vphp_pkg::PH_LENGTH && phase_reg != vphp_pkg::PH_ID)
            begin
                if (s1_end_reg)
                begin
                    phase_next      = vphp_pkg::PH_LENGTH;
                    acc_next        = '0;
                    idx_next        = '0;
                    held_len_next   = '0;
                    held_bytes_next = '0;
                end
            end
            else if (idx_reg >= IDX_MAX)
            begin
                emit        = 1'b1;
                status_next = vphp_pkg::ST_TOO_LONG;
            end
            else if ((s1_byte_reg & vphp_pkg::MORE_MASK) != '0)
            begin
                if (s1_end_reg)
                begin
                    emit        = 1'b1;
                    status_next = vphp_pkg::ST_INCOMPLETE;
                end
                else
                begin
                    acc_next = acc_new;
                    idx_next = idx_new;
                end
            end
            else if (phase_reg == vphp_pkg::PH_LENGTH)
            begin
                if (s1_end_reg)
                begin
                    emit        = 1'b1;
                    status_next = vphp_pkg::ST_INCOMPLETE;
                end
                else
                begin
                    held_len_next   = acc_new;
                    held_bytes_next = idx_new;
                    acc_next        = '0;
                    idx_next        = '0;
                    phase_next      = vphp_pkg::PH_ID;
                end
            end
            else
            begin
                emit        = 1'b1;
                status_next = vphp_pkg::ST_OK;
            end

            if (emit)
            begin
                if (status_next == vphp_pkg::ST_OK)
                begin
                    len_out_next    = held_len_reg;
                    id_out_next     = acc_new;
                    lbytes_out_next = held_bytes_reg;
                end
                else
                begin
                    len_out_next    = '0;
                    id_out_next     = '0;
                    lbytes_out_next = '0;
                end
                acc_next = '0;
                idx_next = '0;
                if (s1_end_reg)
                begin
                    phase_next      = vphp_pkg::PH_LENGTH;
                    held_len_next   = '0;
                    held_bytes_next = '0;
                end
                else
                begin
                    phase_next = vphp_pkg::PH_SKIP;
                end
            end
        end
    end

    always_comb
    begin
        if (in_valid && !in_stall)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (fire)
        begin
            out_valid_next = emit;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            phase_reg      <= vphp_pkg::PH_LENGTH;
            acc_reg        <= '0;
            idx_reg        <= '0;
            held_len_reg   <= '0;
            held_bytes_reg <= '0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
            phase_reg      <= phase_next;
            acc_reg        <= acc_next;
            idx_reg        <= idx_next;
            held_len_reg   <= held_len_next;
            held_bytes_reg <= held_bytes_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg <= data_byte;
            s1_end_reg  <= buffer_end;
        end
        if (fire && emit)
        begin
            status_reg     <= status_next;
            len_out_reg    <= len_out_next;
            id_out_reg     <= id_out_next;
            lbytes_out_reg <= lbytes_out_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign packet_length = $signed(len_out_reg);
    assign packet_id     = $signed(id_out_reg);
    assign length_bytes  = vphp_pkg::COUNT_W'(lbytes_out_reg);

endmodule

### hdl/vphp_checker.sv
// ----------------------------------------------------------------------------
// vphp_checker
// Port-level checks for the varint packet header parser core.
// ----------------------------------------------------------------------------
module vphp_checker #(
    parameter int unsigned MAX_VARINT_BYTES = 5
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_stall,
    input logic [vphp_pkg::DATA_W-1:0]          data_byte,
    input logic                                 buffer_end,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic [vphp_pkg::STATUS_W-1:0]        status,
    input logic signed [vphp_pkg::VALUE_W-1:0]  packet_length,
    input logic signed [vphp_pkg::VALUE_W-1:0]  packet_id,
    input logic [vphp_pkg::COUNT_W-1:0]         length_bytes
);

    localparam logic [vphp_pkg::COUNT_W-1:0] CNT_MAX = vphp_pkg::COUNT_W'(MAX_VARINT_BYTES);

    // A stalled request holds its byte until it is taken.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(data_byte) && $stable(buffer_end))
        else $error("input request changed while stalled");

    // A held request stays presented until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // The input side only waits when a finished result is blocked downstream.
    a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a blocked result");

    // Error results carry zeroed fields.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != vphp_pkg::ST_OK |->
            packet_length == 0 && packet_id == 0 && length_bytes == 0)
        else $error("error result with nonzero fields");

    // A good result used between one and the maximum number of length bytes.
    a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == vphp_pkg::ST_OK |->
            length_bytes != 0 && length_bytes <= CNT_MAX)
        else $error("length byte count out of range");

endmodule

bind varint_packet_header_parser_core vphp_checker #(
    .MAX_VARINT_BYTES(MAX_VARINT_BYTES)
) u_vphp_checker (.*);

### tb/varint_packet_header_parser_core_tb.sv
// ----------------------------------------------------------------------------
// varint_packet_header_parser_core_tb
// Streams received buffers into the header parser, one byte per request, and
// checks every header result against an in-bench decoder of the length and id
// varints. A directed set covers the value extremes, the too-long varints, the
// early buffer ends and the skipping of trailing bytes. Random buffers follow:
// mostly well-formed headers with random content, some cut short, some noise.
// Both sides of the block idle at random, with one long calm stretch.
// ----------------------------------------------------------------------------
module varint_packet_header_parser_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_BYTES    = 5;
    localparam int unsigned RANDOM_ITEMS = 1200;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    typedef logic [vphp_pkg::DATA_W-1:0]   byte_t;
    typedef logic [vphp_pkg::STATUS_W-1:0] status_t;
    typedef logic [vphp_pkg::VALUE_W-1:0]  value_t;
    typedef logic [vphp_pkg::COUNT_W-1:0]  count_t;
    typedef logic [vphp_pkg::PHASE_W-1:0]  phase_t;

    typedef struct {
        status_t status;
        value_t  length;
        value_t  id;
        count_t  count;
    } header_t;

    class header_tracker;
        phase_t      phase;
        value_t      gathered;
        int unsigned taken;
        value_t      held_length;
        count_t      held_count;
        header_t     expected_headers[$];
        int unsigned failures;

        function new();
            failures = 0;
            clear_state();
        endfunction

        function void clear_state();
            phase       = vphp_pkg::PH_LENGTH;
            gathered    = '0;
            taken       = 0;
            held_length = '0;
            held_count  = '0;
        endfunction

        function void finish_header(logic last, status_t st, value_t len, value_t id,
                                    count_t cnt);
            header_t h;
            h.status = st;
            h.length = len;
            h.id     = id;
            h.count  = cnt;
            expected_headers.push_back(h);
            if (last)
            begin
                clear_state();
            end
            else
            begin
                phase    = vphp_pkg::PH_SKIP;
                gathered = '0;
                taken    = 0;
            end
        endfunction

        function void take_byte(byte_t b, logic last);
            value_t bits;
            if (phase != vphp_pkg::PH_LENGTH && phase != vphp_pkg::PH_ID)
            begin
                if (last)
                    clear_state();
                return;
            end
            if (taken >= MAX_BYTES)
            begin
                finish_header(last, vphp_pkg::ST_TOO_LONG, '0, '0, '0);
                return;
            end
            bits     = vphp_pkg::VALUE_W'(b & vphp_pkg::PAYLOAD_MASK);
            gathered = gathered | (bits << (7 * taken));
            taken    = taken + 1;
            if ((b & vphp_pkg::MORE_MASK) != '0)
            begin
                if (last)
                    finish_header(last, vphp_pkg::ST_INCOMPLETE, '0, '0, '0);
                return;
            end
            if (phase == vphp_pkg::PH_LENGTH)
            begin
                held_length = gathered;
                held_count  = vphp_pkg::COUNT_W'(taken);
                gathered    = '0;
                taken       = 0;
                phase       = vphp_pkg::PH_ID;
                if (last)
                    finish_header(last, vphp_pkg::ST_INCOMPLETE, '0, '0, '0);
                return;
            end
            finish_header(last, vphp_pkg::ST_OK, held_length, gathered, held_count);
        endfunction

        function void check_header(status_t st, value_t len, value_t id, count_t cnt);
            header_t h;
            if (expected_headers.size() == 0)
            begin
                $display("%0t: header with none expected: status %0d length %0h id %0h",
                         $realtime, st, len, id);
                failures++;
                return;
            end
            h = expected_headers.pop_front();
            if (st !== h.status)
            begin
                $display("%0t: status expected %0d actual %0d", $realtime, h.status, st);
                failures++;
            end
            if (len !== h.length)
            begin
                $display("%0t: packet_length expected %h actual %h", $realtime, h.length, len);
                failures++;
            end
            if (id !== h.id)
            begin
                $display("%0t: packet_id expected %h actual %h", $realtime, h.id, id);
                failures++;
            end
            if (cnt !== h.count)
            begin
                $display("%0t: length_bytes expected %0d actual %0d", $realtime, h.count, cnt);
                failures++;
            end
        endfunction

        function int unsigned pending();
            return expected_headers.size();
        endfunction
    endclass

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                in_valid = 1'b0;
    logic                                in_stall;
    byte_t                               data_byte = '0;
    logic                                buffer_end = 1'b0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    status_t                             status;
    logic signed [vphp_pkg::VALUE_W-1:0] packet_length;
    logic signed [vphp_pkg::VALUE_W-1:0] packet_id;
    count_t                              length_bytes;

    header_tracker board = new();
    logic          calm = 1'b0;
    int unsigned   sent_items = 0;
    int unsigned   cycle_count = 0;

    varint_packet_header_parser_core #(
        .MAX_VARINT_BYTES(MAX_BYTES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .data_byte(data_byte),
        .buffer_end(buffer_end),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .packet_length(packet_length),
        .packet_id(packet_id),
        .length_bytes(length_bytes)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(99) < 10);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_header(status, packet_length, packet_id, length_bytes);
    end

    task automatic put_byte(input byte_t b, input logic last);
        if (!calm && $urandom_range(99) < 10)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= b;
        buffer_end <= last;
        do
            @(posedge clk);
        while (in_stall);
        board.take_byte(b, last);
        sent_items++;
    endtask

    task automatic send_buffer(input byte_t bytes_q[$]);
        for (int i = 0; i < bytes_q.size(); i++)
            put_byte(bytes_q[i], i == bytes_q.size() - 1);
    endtask

    function automatic void add_varint(ref byte_t bytes_q[$], input int unsigned n);
        for (int unsigned k = 0; k < n; k++)
        begin
            byte_t b;
            b = byte_t'($urandom_range(255));
            b[vphp_pkg::DATA_W-1] = (k + 1 < n);
            bytes_q.push_back(b);
        end
    endfunction

    function automatic int unsigned pick_count();
        if ($urandom_range(99) < 6)
            return $urandom_range(MAX_BYTES + 2, MAX_BYTES + 1);
        return $urandom_range(MAX_BYTES, 1);
    endfunction

    initial
    begin
        byte_t       bytes_q[$];
        int unsigned n_len;
        int unsigned kind;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Smallest header, then widest length with dropped top bits.
        send_buffer('{8'h00, 8'h00});
        send_buffer('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h80, 8'h01});
        // Length varint too long, found on the buffer's last byte.
        send_buffer('{8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80});
        // Buffer ends inside a varint, and right after the length varint.
        send_buffer('{8'h81});
        send_buffer('{8'h7F});
        // Id varint too long, followed by bytes that must be skipped.
        send_buffer('{8'h03, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00});

        while (sent_items < RANDOM_ITEMS + 25)
        begin
            calm = (sent_items >= 500 && sent_items < 750);
            bytes_q.delete();
            kind = $urandom_range(99);
            if (kind < 92)
            begin
                n_len = pick_count();
                add_varint(bytes_q, n_len);
                add_varint(bytes_q, pick_count());
                repeat ($urandom_range(3))
                    bytes_q.push_back(byte_t'($urandom_range(255)));
                if (kind >= 80 && bytes_q.size() > 1)
                    bytes_q = bytes_q[0:$urandom_range(bytes_q.size() - 2)];
            end
            else
            begin
                repeat ($urandom_range(8, 1))
                    bytes_q.push_back(byte_t'($urandom_range(255)));
            end
            send_buffer(bytes_q);
        end
        in_valid <= 1'b0;
        calm = 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (board.failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
